>>> design/stk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stk_pkg: shared types and constants for the STK500v1 command engine
// Word layouts, command codes, register indexes and store addressing.
// ----------------------------------------------------------------------------
package stk_pkg;

	// Firmware store size in bytes (a power of two).
	localparam int STORE_BYTES = 16384;
	localparam int ADDR_W      = $clog2(STORE_BYTES);

	// Input word command codes.
	localparam logic [1:0] CMD_RX   = 2'd0;
	localparam logic [1:0] CMD_TICK = 2'd1;
	localparam logic [1:0] CMD_SLOT = 2'd2;

	// Configuration register indexes.
	localparam logic [2:0] REG_TIMEOUT  = 3'd0;
	localparam logic [2:0] REG_MAJOR    = 3'd1;
	localparam logic [2:0] REG_MINOR    = 3'd2;
	localparam logic [2:0] REG_SIG_1ST  = 3'd3;
	localparam logic [2:0] REG_SIG_2ND  = 3'd4;
	localparam logic [2:0] REG_SIG_3RD  = 3'd5;

	// Protocol bytes.
	localparam logic [7:0] B_INSYNC    = 8'h14;
	localparam logic [7:0] B_OK        = 8'h10;
	localparam logic [7:0] OP_GET_PARM = 8'h41;
	localparam logic [7:0] OP_SET_DEV  = 8'h42;
	localparam logic [7:0] OP_SET_EXT  = 8'h45;
	localparam logic [7:0] OP_LEAVE    = 8'h51;
	localparam logic [7:0] OP_LOAD_ADR = 8'h55;
	localparam logic [7:0] OP_UNIV     = 8'h56;
	localparam logic [7:0] OP_PROG_PG  = 8'h64;
	localparam logic [7:0] OP_READ_PG  = 8'h74;
	localparam logic [7:0] OP_READ_SIG = 8'h75;
	localparam logic [7:0] PARM_MAJOR  = 8'h81;
	localparam logic [7:0] PARM_MINOR  = 8'h82;
	localparam logic [7:0] PARM_UNKN   = 8'h03;
	localparam logic [4:0] SKIP_DEV    = 5'd20;
	localparam logic [4:0] SKIP_EXT    = 5'd5;
	localparam logic [4:0] SKIP_UNIV   = 5'd4;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] rx_byte;
	} in_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       response_last;
		logic       exit_now;
	} out_t;

	// Result of one accepted word, before the output register.
	typedef struct packed {
		logic valid;
		logic use_mem;
		out_t data;
	} res_t;

	// Store access request from the command logic.
	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} mem_req_t;

	// Byte offset 2*word_address + index, wrapped to the store size.
	function automatic logic [ADDR_W-1:0] store_offset(logic [15:0] wa, logic [7:0] idx);
		logic [17:0] sum;
		sum = {1'b0, wa, 1'b0} + {10'd0, idx};
		return sum[ADDR_W-1:0];
	endfunction

endpackage
`default_nettype wire

>>> design/stk_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stk_ram: single-port-write, single-port-read synchronous RAM
// One write and one registered read per cycle; read data holds when idle.
// ----------------------------------------------------------------------------
module stk_ram #(
	parameter int DEPTH = 16384,
	parameter int WIDTH = 8
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

>>> design/stk_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stk_ctrl: command parser and reply sequencer
// Holds parse and reply state plus configuration; issues store accesses.
// ----------------------------------------------------------------------------
module stk_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            accept,
	input  wire stk_pkg::in_t    word,
	input  wire logic            cfg_we,
	input  wire logic [2:0]      cfg_index,
	input  wire logic [15:0]     cfg_data,
	output stk_pkg::res_t        res,
	output stk_pkg::mem_req_t    mem
);
	import stk_pkg::*;

	typedef enum logic [18:0] {
		PH_IDLE        = 19'b0000000000000000001,
		PH_PARAM_WHICH = 19'b0000000000000000010,
		PH_SKIP_PLAIN  = 19'b0000000000000000100,
		PH_SKIP_UNIV   = 19'b0000000000000001000,
		PH_ADDR_LO     = 19'b0000000000000010000,
		PH_ADDR_HI     = 19'b0000000000000100000,
		PH_PROG_LEN_HI = 19'b0000000000001000000,
		PH_PROG_LEN_LO = 19'b0000000000010000000,
		PH_PROG_TYPE   = 19'b0000000000100000000,
		PH_PROG_DATA   = 19'b0000000001000000000,
		PH_READ_LEN_HI = 19'b0000000010000000000,
		PH_READ_LEN_LO = 19'b0000000100000000000,
		PH_READ_TYPE   = 19'b0000001000000000000,
		PH_EOP_PLAIN   = 19'b0000010000000000000,
		PH_EOP_PARAM   = 19'b0000100000000000000,
		PH_EOP_UNIV    = 19'b0001000000000000000,
		PH_EOP_SIGN    = 19'b0010000000000000000,
		PH_EOP_READ    = 19'b0100000000000000000,
		PH_EOP_LEAVE   = 19'b1000000000000000000
	} phase_t;

	typedef enum logic [2:0] {
		RK_NONE, RK_PLAIN, RK_PARAM, RK_UNIV, RK_SIGN, RK_READ, RK_LEAVE
	} rkind_t;

	phase_t      phase_q, phase_d;
	rkind_t      rk_q, rk_d;
	logic [4:0]  skip_q, skip_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  ppos_q, ppos_d;
	logic [15:0] wa_q, wa_d;
	logic [8:0]  rpos_q, rpos_d;
	logic [7:0]  parm_q, parm_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic        await_q, await_d;
	logic        exited_q, exited_d;

	logic [15:0] timeout_q;
	logic [7:0]  major_q, minor_q, sig1_q, sig2_q, sig3_q;

	logic [8:0]  pay_n;
	logic [7:0]  pay_idx;
	logic [7:0]  rx;

	assign rx      = word.rx_byte;
	assign pay_idx = 8'(rpos_q - 9'd1);

	// Payload length of the pending reply.
	always_comb begin
		case (rk_q)
			RK_PARAM, RK_UNIV: pay_n = 9'd1;
			RK_SIGN:           pay_n = 9'd3;
			RK_READ:           pay_n = {1'b0, len_q};
			default:           pay_n = 9'd0;
		endcase
	end

	// Next-state and result logic for one accepted word.
	always_comb begin
		phase_d   = phase_q;
		rk_d      = rk_q;
		skip_d    = skip_q;
		len_d     = len_q;
		ppos_d    = ppos_q;
		wa_d      = wa_q;
		rpos_d    = rpos_q;
		parm_d    = parm_q;
		elapsed_d = elapsed_q;
		await_d   = await_q;
		exited_d  = exited_q;
		res       = '0;
		mem       = '0;
		mem.waddr = store_offset(wa_q, ppos_q);
		mem.wdata = rx;
		mem.raddr = store_offset(wa_q, pay_idx);
		if (accept && !exited_q) begin
			case (word.command)
				CMD_RX: begin
					if (rk_q == RK_NONE) begin
						await_d = 1'b0;
						unique case (phase_q)
							PH_IDLE: begin
								case (rx)
									OP_GET_PARM: phase_d = PH_PARAM_WHICH;
									OP_SET_DEV: begin
										skip_d  = SKIP_DEV;
										phase_d = PH_SKIP_PLAIN;
									end
									OP_SET_EXT: begin
										skip_d  = SKIP_EXT;
										phase_d = PH_SKIP_PLAIN;
									end
									OP_UNIV: begin
										skip_d  = SKIP_UNIV;
										phase_d = PH_SKIP_UNIV;
									end
									OP_LEAVE:    phase_d = PH_EOP_LEAVE;
									OP_LOAD_ADR: phase_d = PH_ADDR_LO;
									OP_PROG_PG:  phase_d = PH_PROG_LEN_HI;
									OP_READ_PG:  phase_d = PH_READ_LEN_HI;
									OP_READ_SIG: phase_d = PH_EOP_SIGN;
									default:     phase_d = PH_EOP_PLAIN;
								endcase
							end
							PH_PARAM_WHICH: begin
								if (rx == PARM_MINOR) begin
									parm_d = minor_q;
								end else if (rx == PARM_MAJOR) begin
									parm_d = major_q;
								end else begin
									parm_d = PARM_UNKN;
								end
								phase_d = PH_EOP_PARAM;
							end
							PH_SKIP_PLAIN, PH_SKIP_UNIV: begin
								if (skip_q != 5'd0) begin
									skip_d = skip_q - 5'd1;
								end
								if (skip_d == 5'd0) begin
									phase_d = (phase_q == PH_SKIP_UNIV) ? PH_EOP_UNIV
									                                    : PH_EOP_PLAIN;
								end
							end
							PH_ADDR_LO: begin
								wa_d    = {wa_q[15:8], rx};
								phase_d = PH_ADDR_HI;
							end
							PH_ADDR_HI: begin
								wa_d    = {rx, wa_q[7:0]};
								phase_d = PH_EOP_PLAIN;
							end
							PH_PROG_LEN_HI: phase_d = PH_PROG_LEN_LO;
							PH_PROG_LEN_LO: begin
								len_d   = rx;
								phase_d = PH_PROG_TYPE;
							end
							PH_PROG_TYPE: begin
								ppos_d  = 8'd0;
								phase_d = (len_q == 8'd0) ? PH_EOP_PLAIN : PH_PROG_DATA;
							end
							PH_PROG_DATA: begin
								mem.we = 1'b1;
								ppos_d = ppos_q + 8'd1;
								if (ppos_d >= len_q) begin
									phase_d = PH_EOP_PLAIN;
								end
							end
							PH_READ_LEN_HI: phase_d = PH_READ_LEN_LO;
							PH_READ_LEN_LO: begin
								len_d   = rx;
								phase_d = PH_READ_TYPE;
							end
							PH_READ_TYPE: phase_d = PH_EOP_READ;
							PH_EOP_PLAIN, PH_EOP_PARAM, PH_EOP_UNIV,
							PH_EOP_SIGN, PH_EOP_READ, PH_EOP_LEAVE: begin
								rpos_d  = 9'd0;
								phase_d = PH_IDLE;
								unique case (phase_q)
									PH_EOP_PARAM: rk_d = RK_PARAM;
									PH_EOP_UNIV:  rk_d = RK_UNIV;
									PH_EOP_SIGN:  rk_d = RK_SIGN;
									PH_EOP_READ:  rk_d = RK_READ;
									PH_EOP_LEAVE: rk_d = RK_LEAVE;
									default:      rk_d = RK_PLAIN;
								endcase
							end
							default: phase_d = PH_IDLE;
						endcase
					end
				end
				CMD_TICK: begin
					if (await_q) begin
						if (elapsed_q != 16'hFFFF) begin
							elapsed_d = elapsed_q + 16'd1;
						end
						if (elapsed_d >= timeout_q) begin
							exited_d          = 1'b1;
							res.valid         = 1'b1;
							res.data.exit_now = 1'b1;
						end
					end
				end
				CMD_SLOT: begin
					if (rk_q != RK_NONE) begin
						res.valid         = 1'b1;
						res.data.tx_valid = 1'b1;
						if (rpos_q == 9'd0) begin
							res.data.tx_byte = B_INSYNC;
						end else if (rpos_q <= pay_n) begin
							case (rk_q)
								RK_PARAM: res.data.tx_byte = parm_q;
								RK_SIGN: begin
									if (rpos_q == 9'd1) begin
										res.data.tx_byte = sig1_q;
									end else if (rpos_q == 9'd2) begin
										res.data.tx_byte = sig2_q;
									end else begin
										res.data.tx_byte = sig3_q;
									end
								end
								RK_READ: begin
									res.use_mem = 1'b1;
									mem.re      = 1'b1;
								end
								default: res.data.tx_byte = 8'h00;
							endcase
						end else begin
							res.data.tx_byte       = B_OK;
							res.data.response_last = 1'b1;
						end
						if (res.data.response_last) begin
							res.data.exit_now = (rk_q == RK_LEAVE);
							exited_d          = (rk_q == RK_LEAVE);
							rk_d              = RK_NONE;
							rpos_d            = 9'd0;
						end else begin
							rpos_d = rpos_q + 9'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Parse and reply state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			rk_q      <= RK_NONE;
			skip_q    <= '0;
			len_q     <= '0;
			ppos_q    <= '0;
			wa_q      <= '0;
			rpos_q    <= '0;
			parm_q    <= '0;
			elapsed_q <= '0;
			await_q   <= 1'b1;
			exited_q  <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			rk_q      <= rk_d;
			skip_q    <= skip_d;
			len_q     <= len_d;
			ppos_q    <= ppos_d;
			wa_q      <= wa_d;
			rpos_q    <= rpos_d;
			parm_q    <= parm_d;
			elapsed_q <= elapsed_d;
			await_q   <= await_d;
			exited_q  <= exited_d;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= 16'd1000;
			major_q   <= 8'd8;
			minor_q   <= 8'd0;
			sig1_q    <= 8'h1E;
			sig2_q    <= 8'h95;
			sig3_q    <= 8'h0F;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TIMEOUT: timeout_q <= cfg_data;
				REG_MAJOR:   major_q   <= cfg_data[7:0];
				REG_MINOR:   minor_q   <= cfg_data[7:0];
				REG_SIG_1ST: sig1_q    <= cfg_data[7:0];
				REG_SIG_2ND: sig2_q    <= cfg_data[7:0];
				REG_SIG_3RD: sig3_q    <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// The store is never read and written by the same word.
	a_no_rw: assert property (@(posedge clk) disable iff (!arst_n) !(mem.we && mem.re))
		else $error("store read and write in one cycle");

	// After exit no further result is produced.
	a_exit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		exited_q |-> !res.valid)
		else $error("result after exit");

	// A store read only happens while a read-page reply is pending.
	a_read_kind: assert property (@(posedge clk) disable iff (!arst_n)
		mem.re |-> (rk_q == RK_READ))
		else $error("store read outside read reply");

endmodule
`default_nettype wire

>>> design/stk500_bootloader_engine_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stk500_bootloader_engine_core: STK500v1 bootloader command engine
// Parses received bytes, stores program pages, and returns reply words.
// ----------------------------------------------------------------------------
// A result word is registered and appears on the output in the cycle after its input word is taken.
// Throughput: one input word per cycle while in_stall is low; an output stall on a held word stalls the input.
// Read-page bytes come from the store's registered read port, muxed onto the output word.
// Reset: control state clears at once; the store is then swept to zero over
// all STORE_BYTES (16384) addresses, and no input word is taken during the sweep.
module stk500_bootloader_engine_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire stk_pkg::in_t  in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output stk_pkg::out_t      out_data,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [15:0]   cfg_data
);
	import stk_pkg::*;

	logic              accept;
	res_t              res;
	mem_req_t          mreq;
	logic              clr_busy_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [7:0]        ram_rdata;
	logic              out_valid_q;
	logic              use_mem_q;
	out_t              data_q;

	assign in_stall = clr_busy_q || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	stk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.word      (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.res       (res),
		.mem       (mreq)
	);

	// Clearing sweep after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == '1) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Store port selection.
	assign ram_we    = clr_busy_q || mreq.we;
	assign ram_waddr = clr_busy_q ? clr_addr_q : mreq.waddr;
	assign ram_wdata = clr_busy_q ? 8'h00 : mreq.wdata;
	assign ram_re    = mreq.re;

	stk_ram #(
		.DEPTH (STORE_BYTES),
		.WIDTH (8)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (mreq.raddr),
		.rdata (ram_rdata)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= accept && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q    <= res.data;
			use_mem_q <= res.use_mem;
		end
	end

	// Read-page bytes take the registered store data.
	always_comb begin
		out_data = data_q;
		if (use_mem_q) begin
			out_data.tx_byte = ram_rdata;
		end
	end
	assign out_valid = out_valid_q;

	// No word is taken during the clearing sweep.
	a_clr_stall: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> in_stall)
		else $error("input taken during clear");

	// Store reads come only from accepted words.
	a_read_acc: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> accept)
		else $error("store read without accepted word");

	// A stalled store-sourced word keeps its read data.
	a_hold_rd: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall && use_mem_q) |=> $stable(ram_rdata))
		else $error("read data changed under stall");

endmodule
`default_nettype wire

>>> bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the STK500v1 bootloader command engine
// Drives whole command frames, ticks, transmit slots and noise words through
// the valid/stall input channel, predicts every reply word with a model of the
// parser kept here, and compares each accepted output word field by field.
// ----------------------------------------------------------------------------
module testbench;
	import stk_pkg::*;

	localparam int CYCLE_LIMIT = 600000;
	localparam int RANDOM_WORDS = 1700;
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam logic [7:0] EOP_MARK = 8'h20;

	typedef enum int {
		PH_IDLE, PH_PARAM_WHICH, PH_SKIP_PLAIN, PH_SKIP_UNIV, PH_ADDR_LO, PH_ADDR_HI,
		PH_PROG_LEN_HI, PH_PROG_LEN_LO, PH_PROG_TYPE, PH_PROG_DATA,
		PH_READ_LEN_HI, PH_READ_LEN_LO, PH_READ_TYPE,
		PH_EOP_PLAIN, PH_EOP_PARAM, PH_EOP_UNIV, PH_EOP_SIGN, PH_EOP_READ, PH_EOP_LEAVE
	} phase_e;

	typedef enum int {
		RK_NONE, RK_PLAIN, RK_PARAM, RK_UNIV, RK_SIGN, RK_READ, RK_LEAVE
	} reply_e;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_t         in_data;
	logic        out_valid;
	logic        out_stall;
	out_t        out_data;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	stk500_bootloader_engine_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copies of the registers and the parser state.
	logic [15:0] tmo_limit;
	logic [7:0]  major_ver;
	logic [7:0]  minor_ver;
	logic [7:0]  sig_bytes [3];
	phase_e      phase;
	reply_e      reply_kind;
	int unsigned skip_left;
	int unsigned page_len;
	int unsigned page_pos;
	logic [15:0] word_addr;
	int unsigned reply_pos;
	logic [7:0]  param_answer;
	logic [15:0] ms_count;
	logic        first_pending;
	logic        exited;
	logic [7:0]  flash_image [STORE_BYTES];

	out_t        expected_replies [$];
	int          failures;
	int          words_sent;
	int unsigned cycles;
	logic        steady;
	logic        leave_allowed;

	// Sampled output side, taken at the falling edge where all is stable.
	logic        ov_s;
	logic        os_s;
	out_t        od_s;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned flash_offset(int unsigned idx);
		return (int'(word_addr) * 2 + idx) % STORE_BYTES;
	endfunction

	// Parser step for one received byte.
	function automatic void parse_byte(logic [7:0] b);
		first_pending = 1'b0;
		case (phase)
			PH_IDLE: begin
				case (b)
					OP_GET_PARM: phase = PH_PARAM_WHICH;
					OP_SET_DEV: begin
						skip_left = SKIP_DEV;
						phase = PH_SKIP_PLAIN;
					end
					OP_SET_EXT: begin
						skip_left = SKIP_EXT;
						phase = PH_SKIP_PLAIN;
					end
					OP_UNIV: begin
						skip_left = SKIP_UNIV;
						phase = PH_SKIP_UNIV;
					end
					OP_LEAVE: phase = PH_EOP_LEAVE;
					OP_LOAD_ADR: phase = PH_ADDR_LO;
					OP_PROG_PG: phase = PH_PROG_LEN_HI;
					OP_READ_PG: phase = PH_READ_LEN_HI;
					OP_READ_SIG: phase = PH_EOP_SIGN;
					default: phase = PH_EOP_PLAIN;
				endcase
			end
			PH_PARAM_WHICH: begin
				if (b == PARM_MINOR)
					param_answer = minor_ver;
				else if (b == PARM_MAJOR)
					param_answer = major_ver;
				else
					param_answer = PARM_UNKN;
				phase = PH_EOP_PARAM;
			end
			PH_SKIP_PLAIN, PH_SKIP_UNIV: begin
				if (skip_left > 0)
					skip_left--;
				if (skip_left == 0)
					phase = (phase == PH_SKIP_UNIV) ? PH_EOP_UNIV : PH_EOP_PLAIN;
			end
			PH_ADDR_LO: begin
				word_addr[7:0] = b;
				phase = PH_ADDR_HI;
			end
			PH_ADDR_HI: begin
				word_addr[15:8] = b;
				phase = PH_EOP_PLAIN;
			end
			PH_PROG_LEN_HI: phase = PH_PROG_LEN_LO;
			PH_PROG_LEN_LO: begin
				page_len = b;
				phase = PH_PROG_TYPE;
			end
			PH_PROG_TYPE: begin
				page_pos = 0;
				phase = (page_len == 0) ? PH_EOP_PLAIN : PH_PROG_DATA;
			end
			PH_PROG_DATA: begin
				flash_image[flash_offset(page_pos)] = b;
				page_pos = (page_pos + 1) & 8'hFF;
				if (page_pos >= page_len)
					phase = PH_EOP_PLAIN;
			end
			PH_READ_LEN_HI: phase = PH_READ_LEN_LO;
			PH_READ_LEN_LO: begin
				page_len = b;
				phase = PH_READ_TYPE;
			end
			PH_READ_TYPE: phase = PH_EOP_READ;
			default: begin
				// Any byte closes the command, a bad end marker included.
				case (phase)
					PH_EOP_PARAM: reply_kind = RK_PARAM;
					PH_EOP_UNIV:  reply_kind = RK_UNIV;
					PH_EOP_SIGN:  reply_kind = RK_SIGN;
					PH_EOP_READ:  reply_kind = RK_READ;
					PH_EOP_LEAVE: reply_kind = RK_LEAVE;
					default:      reply_kind = RK_PLAIN;
				endcase
				reply_pos = 0;
				phase = PH_IDLE;
			end
		endcase
	endfunction

	// Expected output for one accepted input word, if it causes one.
	function automatic void predict_reply(in_t w);
		out_t        r;
		int unsigned n;
		if (exited)
			return;
		r = '0;
		case (w.command)
			CMD_RX: begin
				if (reply_kind == RK_NONE)
					parse_byte(w.rx_byte);
			end
			CMD_TICK: begin
				if (first_pending) begin
					if (ms_count != 16'hFFFF)
						ms_count++;
					if (ms_count >= tmo_limit) begin
						exited = 1'b1;
						r.exit_now = 1'b1;
						expected_replies.push_back(r);
					end
				end
			end
			CMD_SLOT: begin
				if (reply_kind != RK_NONE) begin
					case (reply_kind)
						RK_PARAM, RK_UNIV: n = 1;
						RK_SIGN: n = 3;
						RK_READ: n = page_len;
						default: n = 0;
					endcase
					r.tx_valid = 1'b1;
					if (reply_pos == 0) begin
						r.tx_byte = B_INSYNC;
					end else if (reply_pos <= n) begin
						case (reply_kind)
							RK_PARAM: r.tx_byte = param_answer;
							RK_SIGN:  r.tx_byte = sig_bytes[reply_pos - 1];
							RK_READ:  r.tx_byte = flash_image[flash_offset(reply_pos - 1)];
							default:  r.tx_byte = 8'h00;
						endcase
					end else begin
						r.tx_byte = B_OK;
						r.response_last = 1'b1;
					end
					if (r.response_last) begin
						r.exit_now = (reply_kind == RK_LEAVE);
						exited = r.exit_now;
						reply_kind = RK_NONE;
						reply_pos = 0;
					end else begin
						reply_pos = (reply_pos + 1) & 9'h1FF;
					end
					expected_replies.push_back(r);
				end
			end
			default: ;
		endcase
	endfunction

	always @(negedge clk) begin
		ov_s <= out_valid;
		os_s <= out_stall;
		od_s <= out_data;
	end

	// Receiver stall, quiet during the steady stretch.
	always @(posedge clk) begin
		out_stall <= steady ? 1'b0 : ($urandom_range(99) < 12);
	end

	// Compare every accepted output word with the oldest expectation.
	always @(posedge clk) begin
		out_t e;
		if (arst_n && ov_s && !os_s) begin
			if (expected_replies.size() == 0) begin
				$error("unexpected word %h", od_s);
				failures++;
			end else begin
				e = expected_replies.pop_front();
				if (od_s.tx_valid !== e.tx_valid) begin
					$error("tx_valid expected %0d actual %0d", e.tx_valid, od_s.tx_valid);
					failures++;
				end
				if (od_s.tx_byte !== e.tx_byte) begin
					$error("tx_byte expected %h actual %h", e.tx_byte, od_s.tx_byte);
					failures++;
				end
				if (od_s.response_last !== e.response_last) begin
					$error("response_last expected %0d actual %0d", e.response_last,
						od_s.response_last);
					failures++;
				end
				if (od_s.exit_now !== e.exit_now) begin
					$error("exit_now expected %0d actual %0d", e.exit_now, od_s.exit_now);
					failures++;
				end
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Send one word; called at a rising edge, returns at the accepting edge.
	task automatic send_word(logic [1:0] cmd, logic [7:0] b);
		in_t w;
		logic took;
		w.command = cmd;
		w.rx_byte = b;
		in_valid <= 1'b1;
		in_data  <= w;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		predict_reply(w);
		words_sent++;
		if (!steady && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Received byte; a stray leave opcode is swapped out until the last test.
	task automatic send_byte(logic [7:0] b);
		if (!leave_allowed && phase == PH_IDLE && reply_kind == RK_NONE && b == OP_LEAVE)
			b = 8'h50;
		send_word(CMD_RX, b);
	endtask

	task automatic send_frame(logic [7:0] bytes [$]);
		foreach (bytes[i])
			send_byte(bytes[i]);
	endtask

	// Finish any open command and take its whole reply, with some noise.
	task automatic drain_reply();
		while (!exited && (phase != PH_IDLE || reply_kind != RK_NONE)) begin
			if (reply_kind == RK_NONE)
				send_byte(8'($urandom_range(255)));
			else if ($urandom_range(99) < 8)
				send_word(2'($urandom_range(3)), 8'($urandom_range(255)));
			else
				send_word(CMD_SLOT, 8'($urandom_range(255)));
		end
	endtask

	// Wait until the block has nothing left to say.
	task automatic settle();
		in_valid <= 1'b0;
		wait (expected_replies.size() == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_settings(logic [15:0] t, logic [7:0] maj, logic [7:0] mnr,
		logic [7:0] s1, logic [7:0] s2, logic [7:0] s3);
		logic [15:0] vals [6];
		vals = '{t, {8'd0, maj}, {8'd0, mnr}, {8'd0, s1}, {8'd0, s2}, {8'd0, s3}};
		settle();
		for (int i = 0; i < 6; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= i[2:0];
			cfg_data  <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		tmo_limit = t;
		major_ver = maj;
		minor_ver = mnr;
		sig_bytes = '{s1, s2, s3};
		@(posedge clk);
	endtask

	function automatic logic [7:0] end_byte();
		return ($urandom_range(99) < 10) ? 8'($urandom_range(255)) : EOP_MARK;
	endfunction

	function automatic int unsigned page_size();
		return ($urandom_range(99) < 3) ? 255 : $urandom_range(0, 16);
	endfunction

	// Build one command frame with random content and an occasional bad end marker.
	function automatic void build_frame(int pick, ref logic [7:0] f [$]);
		int unsigned n;
		f = {};
		case (pick)
			0: f = {OP_GET_PARM, ($urandom_range(2) == 0) ? 8'($urandom_range(255)) :
				(($urandom_range(1) == 0) ? PARM_MAJOR : PARM_MINOR), end_byte()};
			1, 2, 3: begin
				f.push_back(pick == 1 ? OP_SET_DEV : (pick == 2 ? OP_SET_EXT : OP_UNIV));
				n = (pick == 1) ? SKIP_DEV : (pick == 2 ? SKIP_EXT : SKIP_UNIV);
				repeat (n) f.push_back(8'($urandom_range(255)));
				f.push_back(end_byte());
			end
			4: f = {OP_LOAD_ADR, 8'($urandom_range(255)), 8'($urandom_range(255)), end_byte()};
			5: begin
				n = page_size();
				f = {OP_PROG_PG, 8'($urandom_range(255)), 8'(n), 8'($urandom_range(255))};
				repeat (n) f.push_back(8'($urandom_range(255)));
				f.push_back(end_byte());
			end
			6: f = {OP_READ_PG, 8'($urandom_range(255)), 8'(page_size()),
				8'($urandom_range(255)), end_byte()};
			7: f = {OP_READ_SIG, end_byte()};
			default: f = {8'($urandom_range(255)), end_byte()};
		endcase
	endfunction

	// Ticks before the first byte, below a large timeout: no exit.
	task automatic test_early_ticks();
		apply_settings(16'hFFFF, 8'd8, 8'd0, 8'h1E, 8'h95, 8'h0F);
		repeat (12) send_word(CMD_TICK, 8'($urandom_range(255)));
		send_word(CMD_SLOT, 8'h00);
		send_word(CMD_NONE, 8'hFF);
	endtask

	// Parameter queries and the signature, with extreme version values.
	task automatic test_queries();
		send_frame({OP_GET_PARM, PARM_MAJOR, EOP_MARK});
		drain_reply();
		apply_settings(16'd1, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hA5);
		send_frame({OP_GET_PARM, PARM_MINOR, EOP_MARK, OP_GET_PARM, PARM_UNKN, 8'hFF});
		drain_reply();
		send_frame({OP_GET_PARM, 8'h00, EOP_MARK, OP_READ_SIG, 8'h00});
		drain_reply();
		// Ticks no longer count once a byte has come in.
		repeat (3) send_word(CMD_TICK, 8'h00);
	endtask

	// Device setup, universal, unknown opcodes and bad end markers.
	task automatic test_setup();
		logic [7:0] f [$];
		for (int p = 1; p <= 3; p++) begin
			build_frame(p, f);
			send_frame(f);
			drain_reply();
		end
		send_frame({8'h00, 8'h00, 8'hFF, 8'hFF});
		drain_reply();
	endtask

	// Page writes and reads at the address extremes, wrap and empty pages.
	task automatic test_pages();
		send_frame({OP_LOAD_ADR, 8'hFF, 8'hFF, EOP_MARK});
		drain_reply();
		send_frame({OP_PROG_PG, 8'h00, 8'd4, 8'h46, 8'hDE, 8'hAD, 8'hBE, 8'hEF, EOP_MARK});
		drain_reply();
		send_frame({OP_READ_PG, 8'h00, 8'd6, 8'h46, EOP_MARK});
		// A byte while the reply is pending is dropped.
		send_byte(OP_READ_SIG);
		drain_reply();
		send_frame({OP_PROG_PG, 8'h01, 8'd0, 8'h46, EOP_MARK});
		drain_reply();
		send_frame({OP_LOAD_ADR, 8'h00, 8'h00, EOP_MARK, OP_READ_PG, 8'h00, 8'd0, 8'h46, 8'h20});
		drain_reply();
	endtask

	// Random frames, broken sequences and register changes between phases.
	task automatic test_random();
		logic [7:0] f [$];
		logic [1:0] cmd;
		int goal;
		int next_cfg;
		goal = words_sent + RANDOM_WORDS;
		next_cfg = words_sent + 300;
		while (words_sent < goal) begin
			steady = (words_sent > goal - 400) && (words_sent < goal - 150);
			if ($urandom_range(99) < 8) begin
				// Noise bytes go through the leave filter like any other byte.
				repeat ($urandom_range(1, 6)) begin
					cmd = 2'($urandom_range(3));
					if (cmd == CMD_RX)
						send_byte(8'($urandom_range(255)));
					else
						send_word(cmd, 8'($urandom_range(255)));
				end
			end else begin
				build_frame($urandom_range(8), f);
				send_frame(f);
			end
			drain_reply();
			if (words_sent >= next_cfg) begin
				next_cfg = words_sent + 300;
				if ($urandom_range(1) == 0)
					apply_settings(16'($urandom_range(1, 65535)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)),
						8'($urandom_range(255)), 8'($urandom_range(255)));
				else
					apply_settings(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
			end
		end
		steady = 1'b0;
	endtask

	// Leave: the closing OK carries the exit, then everything is ignored.
	task automatic test_leave();
		leave_allowed = 1'b1;
		send_frame({OP_LEAVE, EOP_MARK});
		drain_reply();
		send_word(CMD_SLOT, 8'h00);
		send_frame({OP_READ_SIG, EOP_MARK});
		send_word(CMD_TICK, 8'h00);
		send_word(CMD_SLOT, 8'h00);
		in_valid <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_TIMEOUT;
		cfg_data = '0;
		failures = 0;
		words_sent = 0;
		cycles = 0;
		steady = 1'b0;
		leave_allowed = 1'b0;
		tmo_limit = 16'd1000;
		major_ver = 8'd8;
		minor_ver = 8'd0;
		sig_bytes = '{8'h1E, 8'h95, 8'h0F};
		phase = PH_IDLE;
		reply_kind = RK_NONE;
		skip_left = 0;
		page_len = 0;
		page_pos = 0;
		word_addr = '0;
		reply_pos = 0;
		param_answer = '0;
		ms_count = '0;
		first_pending = 1'b1;
		exited = 1'b0;
		foreach (flash_image[i])
			flash_image[i] = 8'h00;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_early_ticks();
		test_queries();
		test_setup();
		test_pages();
		test_random();
		test_leave();

		wait (expected_replies.size() == 0);
		repeat (10) @(posedge clk);
		if (failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

>>> stk500_bootloader_engine_core.f
design/stk_pkg.sv
design/stk_ram.sv
design/stk_ctrl.sv
design/stk500_bootloader_engine_core.sv
bench/testbench.sv
